// ----- hdl/lz4d_pkg.sv -----
// shared types and constants for the lz4 block decoder
package lz4d_pkg;

  localparam int unsigned WindowBytes   = 65536;
  localparam int unsigned AddrW         = $clog2(WindowBytes);
  localparam int unsigned MinMatch      = 4;
  localparam int unsigned LastLiterals  = 5;
  localparam int unsigned NibBits       = 4;
  localparam int unsigned LenW          = 24;

  localparam logic [NibBits-1:0] NibMax = {NibBits{1'b1}};

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StBadOff   = 2'd1;
  localparam logic [1:0] StOverflow = 2'd2;
  localparam logic [1:0] StBadFinal = 2'd3;

  // history port requests from the parser
  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic             wr_lit;
    logic [AddrW-1:0] wr_addr;
    logic [7:0]       wr_data;
  } hist_req_t;

  // result word heading to the output register
  typedef struct packed {
    logic [7:0] out_byte;
    logic       copy_pending;
    logic [1:0] status;
    logic       block_done;
  } res_t;

endpackage

// ----- hdl/lz4d_history.sv -----
// history window memory with registered synchronous read
module lz4d_history
  import lz4d_pkg::*;
(
  input  logic       clk_i,
  input  hist_req_t  req_i,
  output logic [7:0] rd_data_o
);

  logic [7:0] mem_q [WindowBytes];

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_o <= mem_q[req_i.rd_addr];
    end
  end

endmodule

// ----- hdl/lz4d_parser.sv -----
// sequence parser: token, length extensions, literals, offset, match copy
module lz4d_parser
  import lz4d_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [LenW-1:0] exp_size_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            action_i,
  input  logic [7:0]      in_byte_i,
  input  logic            in_last_i,
  output hist_req_t       hreq_o,
  input  logic [7:0]      hist_rd_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output res_t            out_res_o
);

  localparam logic [2:0] PhToken  = 3'd0;
  localparam logic [2:0] PhLitExt = 3'd1;
  localparam logic [2:0] PhLit    = 3'd2;
  localparam logic [2:0] PhOffLo  = 3'd3;
  localparam logic [2:0] PhOffHi  = 3'd4;
  localparam logic [2:0] PhMatExt = 3'd5;
  localparam logic [2:0] PhCopy   = 3'd6;
  localparam logic [2:0] PhHalt   = 3'd7;

  localparam logic [LenW:0] SatMax = {1'b0, {LenW{1'b1}}};

  logic [2:0]      phase_q, phase_d;
  logic [LenW-1:0] wcnt_q, wcnt_d, lit_q, lit_d, mlen_q, mlen_d;
  logic [15:0]     off_q, off_d;
  logic [NibBits-1:0] nib_q, nib_d;

  // stage 1 holds the result; for copy bytes the data comes from memory
  logic s1_valid_q;
  logic s1_mem_q;
  res_t s1_res_q;
  res_t s1_out;
  logic [7:0] fwd_data_q;
  logic fwd_q;

  // output register
  logic ov_q;
  res_t ores_q;

  logic s1_free, ovl_free, accept;
  logic emit;
  res_t res;
  logic mem_rd;
  hist_req_t hreq;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [LenW:0] sum_tmp, mlen_full;
  logic [LenW-1:0] limit;

  function automatic logic [LenW-1:0] sat_add(logic [LenW-1:0] a, logic [LenW-1:0] b);
    logic [LenW:0] v;
    v = {1'b0, a} + {1'b0, b};
    return v[LenW] ? SatMax[LenW-1:0] : v[LenW-1:0];
  endfunction

  assign ovl_free = !ov_q || out_ready_i;
  assign s1_free  = !s1_valid_q || ovl_free;
  assign in_ready_o = s1_free;
  assign accept = in_valid_i && in_ready_o;
  assign rd_addr = AddrW'(wcnt_q - LenW'(off_q));
  assign wr_addr = wcnt_q[AddrW-1:0];
  assign limit = (exp_size_i >= LenW'(LastLiterals)) ? exp_size_i - LenW'(LastLiterals)
                                                     : '0;

  always_comb begin
    phase_d = phase_q;
    wcnt_d  = wcnt_q;
    lit_d   = lit_q;
    mlen_d  = mlen_q;
    off_d   = off_q;
    nib_d   = nib_q;
    emit    = 1'b0;
    mem_rd  = 1'b0;
    res     = '0;
    hreq    = '0;
    sum_tmp = '0;
    mlen_full = '0;
    hreq.rd_addr = rd_addr;
    hreq.wr_addr = wr_addr;
    if (accept && phase_q != PhHalt) begin
      if (action_i) begin
        if (phase_q == PhCopy) begin
          mem_rd = 1'b1;
          hreq.rd_en = 1'b1;
          hreq.wr_en = 1'b1;
          wcnt_d = wcnt_q + 1'b1;
          mlen_d = mlen_q - 1'b1;
          if (mlen_d == '0) phase_d = PhToken;
          emit = 1'b1;
          res.copy_pending = (mlen_d != '0);
        end
      end else begin
        case (phase_q)
          PhToken: begin
            nib_d = in_byte_i[NibBits-1:0];
            if (in_last_i) begin
              emit = 1'b1; phase_d = PhHalt; res.block_done = 1'b1;
              res.status = (in_byte_i[7:NibBits] != '0 || wcnt_q != exp_size_i)
                           ? StBadFinal : StOk;
            end else begin
              lit_d = LenW'(in_byte_i[7:NibBits]);
              if (in_byte_i[7:NibBits] == NibMax) phase_d = PhLitExt;
              else if (in_byte_i[7:NibBits] != '0) phase_d = PhLit;
              else phase_d = PhOffLo;
            end
          end
          PhLitExt: begin
            if (in_last_i) begin
              emit = 1'b1; phase_d = PhHalt; res.block_done = 1'b1;
              res.status = StBadFinal;
            end else begin
              lit_d = sat_add(lit_q, LenW'(in_byte_i));
              if (in_byte_i != 8'hFF) phase_d = PhLit;
            end
          end
          PhLit: begin
            emit = 1'b1;
            if (wcnt_q >= exp_size_i) begin
              phase_d = PhHalt; res.block_done = 1'b1; res.status = StOverflow;
            end else begin
              hreq.wr_en = 1'b1;
              hreq.wr_lit = 1'b1;
              hreq.wr_data = in_byte_i;
              wcnt_d = wcnt_q + 1'b1;
              lit_d = lit_q - 1'b1;
              res.out_byte = in_byte_i;
              if (in_last_i) begin
                phase_d = PhHalt; res.block_done = 1'b1;
                res.status = (lit_d == '0 && wcnt_d == exp_size_i) ? StOk : StBadFinal;
              end else if (lit_d == '0) begin
                phase_d = PhOffLo;
              end
            end
          end
          PhOffLo, PhOffHi, PhMatExt: begin
            if (in_last_i) begin
              emit = 1'b1; phase_d = PhHalt; res.block_done = 1'b1;
              res.status = StBadFinal;
            end else if (phase_q == PhOffLo) begin
              off_d = {8'h00, in_byte_i};
              phase_d = PhOffHi;
            end else begin
              if (phase_q == PhOffHi) begin
                off_d = {in_byte_i, off_q[7:0]};
                if (nib_q == NibMax) begin
                  mlen_d = LenW'(NibMax);
                  phase_d = PhMatExt;
                end else begin
                  mlen_full = (LenW+1)'(nib_q) + (LenW+1)'(MinMatch);
                end
              end else begin
                mlen_d = sat_add(mlen_q, LenW'(in_byte_i));
                if (in_byte_i != 8'hFF) begin
                  mlen_full = {1'b0, sat_add(mlen_d, LenW'(MinMatch))};
                end
              end
              if (mlen_full != '0) begin
                emit = 1'b1;
                sum_tmp = {1'b0, wcnt_q} + mlen_full;
                if (off_d == '0 || (LenW+1)'(off_d) > {1'b0, wcnt_q}) begin
                  phase_d = PhHalt; res.block_done = 1'b1; res.status = StBadOff;
                end else if (sum_tmp > {1'b0, exp_size_i}) begin
                  phase_d = PhHalt; res.block_done = 1'b1; res.status = StOverflow;
                end else if (sum_tmp > {1'b0, limit}) begin
                  phase_d = PhHalt; res.block_done = 1'b1; res.status = StBadFinal;
                end else begin
                  mlen_d = mlen_full[LenW-1:0];
                  phase_d = PhCopy;
                  res.copy_pending = 1'b1;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  // copy writes take the read data in the following cycle, through the port mux
  logic            cw_q;
  logic [AddrW-1:0] cw_addr_q;
  logic [7:0]      copy_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhToken;
      wcnt_q <= '0; lit_q <= '0; mlen_q <= '0; off_q <= '0; nib_q <= '0;
      s1_valid_q <= 1'b0; ov_q <= 1'b0; cw_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      wcnt_q <= wcnt_d; lit_q <= lit_d; mlen_q <= mlen_d;
      off_q <= off_d; nib_q <= nib_d;
      if (s1_free) s1_valid_q <= accept && emit;
      if (ovl_free) ov_q <= s1_valid_q;
      cw_q <= s1_free && accept && emit && mem_rd;
    end
  end

  // forward: a copy reading the address that the previous copy writes this cycle
  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      s1_res_q <= res;
      s1_mem_q <= mem_rd;
      fwd_q <= cw_q && mem_rd && (cw_addr_q == rd_addr);
      fwd_data_q <= copy_byte;
    end
    if (ovl_free && s1_valid_q) begin
      ores_q <= s1_out;
    end
    cw_addr_q <= wr_addr;
  end

  assign copy_byte = fwd_q ? fwd_data_q : hist_rd_i;

  always_comb begin
    s1_out = s1_res_q;
    if (s1_mem_q) s1_out.out_byte = copy_byte;
  end

  // literals write when accepted, copies in the cycle after their read
  logic pend_we;
  assign pend_we = hreq.wr_en && hreq.wr_lit;

  // note: copy write issues in the following cycle through the port mux below
  hist_req_t req_mux;
  always_comb begin
    req_mux = hreq;
    req_mux.wr_en = pend_we || cw_q;
    req_mux.wr_addr = cw_q ? cw_addr_q : wr_addr;
    req_mux.wr_data = cw_q ? copy_byte : in_byte_i;
  end

  assign hreq_o = req_mux;
  assign out_valid_o = ov_q;
  assign out_res_o = ores_q;

  // a stalled result keeps its contents
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && !out_ready_i |=> ov_q && $stable(ores_q));
  // literal and copy writes never meet in one cycle
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pend_we && cw_q));
  // a match in progress always has bytes left
  a_copy_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhCopy |-> mlen_q != '0);
  // no word is taken while both stages are full and stalled
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && ov_q && !out_ready_i |-> !in_ready_o);

endmodule

// ----- hdl/lz4_block_decoder.sv -----
// top level of the lz4 block decoder
// usage:
//  - s_axis carries one word per item: tdata = in_byte, tuser = action,
//    tlast marks the final compressed byte of the block
//  - action 0 pushes a compressed byte, action 1 pulls one byte of a match
//  - m_axis returns results: tdata = {status, copy_pending, out_byte},
//    tlast is block_done
//  - headers (token, extension and offset bytes) give no result word
//  - a match header ends with an announce word with copy_pending set;
//    the match is then drained one pull word per byte
//  - throughput: one word per cycle unless m_axis stalls; registered output
//  - history is a 64 KiB single-port-write memory with registered read;
//    copies write back in the cycle after reading, forwarded on overlap
//  - user loads expected_output_size (cfg_valid_i/cfg_ready_o) only while idle;
//    not enforced by the block; reset clears the parser and sizes, not history
//  - when m_axis stalls, a result waits in the output register while words
//    are taken until one more result fills stage 1, then s_axis tready drops
module lz4_block_decoder
  import lz4d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // in_byte
  input  logic        s_axis_tuser,  // action
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // out_byte, copy_pending, status, zero pad
  output logic        m_axis_tlast
);

  logic [LenW-1:0] exp_q;
  hist_req_t hreq;
  logic [7:0] hrd;
  res_t res;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) exp_q <= '0;
    else if (cfg_valid_i && cfg_ready_o) exp_q <= cfg_data_i;
  end

  lz4d_parser u_parser (
    .clk_i, .rst_ni,
    .exp_size_i (exp_q),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .action_i   (s_axis_tuser),
    .in_byte_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .hreq_o     (hreq),
    .hist_rd_i  (hrd),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_res_o  (res)
  );

  lz4d_history u_hist (
    .clk_i,
    .req_i     (hreq),
    .rd_data_o (hrd)
  );

  assign m_axis_tdata = {5'd0, res.status, res.copy_pending, res.out_byte};
  assign m_axis_tlast = res.block_done;

endmodule

// ----- tb/lz4_block_decoder_tb.sv -----
// self-checking testbench for the lz4 block decoder: random lz4 sequences against a predictor
module lz4_block_decoder_tb
  import lz4d_pkg::*;
();

  typedef enum logic [2:0] {
    P_TOKEN, P_LIT_EXT, P_LIT, P_OFF_LO, P_OFF_HI, P_MAT_EXT, P_COPY, P_HALT
  } parse_e;

  localparam logic ActPush = 1'b0;
  localparam logic ActPull = 1'b1;
  localparam int unsigned SizeMax = 24'hFFFFFF;
  localparam int unsigned IdleLimit = 3000;

  typedef struct packed {
    logic       act;
    logic [7:0] data;
    logic       last;
  } word_t;

  // predicts decoder results and checks them in order
  class lz4_scoreboard;
    logic [7:0]  window [WindowBytes];
    int unsigned out_size, out_count, lit_left, mat_left, mat_off, mat_nib;
    parse_e      ph;
    res_t        expect_q[$];
    int          errors;

    function new();
      ph = P_TOKEN;
      out_size = 0; out_count = 0; lit_left = 0; mat_left = 0;
      mat_off = 0; mat_nib = 0; errors = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void add(logic [7:0] b, logic pend, logic [1:0] st, logic done);
      res_t r;
      r.out_byte = b; r.copy_pending = pend; r.status = st; r.block_done = done;
      expect_q.push_back(r);
    endfunction

    function void end_block(logic [7:0] b, logic [1:0] st);
      ph = P_HALT;
      add(b, 1'b0, st, 1'b1);
    endfunction

    function int unsigned sat24(int unsigned a, int unsigned b);
      return (a + b > SizeMax) ? SizeMax : a + b;
    endfunction

    function void start_match(int unsigned len);
      int unsigned limit;
      limit = (out_size >= LastLiterals) ? out_size - LastLiterals : 0;
      if (mat_off == 0 || mat_off > out_count || mat_off > WindowBytes) end_block(8'h00, StBadOff);
      else if (out_count + len > out_size) end_block(8'h00, StOverflow);
      else if (out_count + len > limit) end_block(8'h00, StBadFinal);
      else begin
        mat_left = len;
        ph = P_COPY;
        add(8'h00, 1'b1, StOk, 1'b0);
      end
    endfunction

    // one accepted input word
    function void note(word_t w);
      logic [7:0] v;
      int unsigned lit;
      if (ph == P_HALT) return;
      if (w.act == ActPull) begin
        if (ph != P_COPY) return;
        v = window[(out_count - mat_off) % WindowBytes];
        window[out_count % WindowBytes] = v;
        out_count = (out_count + 1) & SizeMax;
        mat_left--;
        if (mat_left == 0) ph = P_TOKEN;
        add(v, mat_left != 0, StOk, 1'b0);
        return;
      end
      case (ph)
        P_TOKEN: begin
          lit = w.data[7:4];
          mat_nib = w.data[3:0];
          if (w.last) begin
            if (lit != 0) end_block(8'h00, StBadFinal);
            else end_block(8'h00, (out_count == out_size) ? StOk : StBadFinal);
          end else begin
            lit_left = lit;
            if (lit == NibMax) ph = P_LIT_EXT;
            else if (lit != 0) ph = P_LIT;
            else ph = P_OFF_LO;
          end
        end
        P_LIT_EXT: begin
          if (w.last) end_block(8'h00, StBadFinal);
          else begin
            lit_left = sat24(lit_left, w.data);
            if (w.data != 8'hFF) ph = P_LIT;
          end
        end
        P_LIT: begin
          if (out_count >= out_size) end_block(8'h00, StOverflow);
          else begin
            window[out_count % WindowBytes] = w.data;
            out_count = (out_count + 1) & SizeMax;
            lit_left--;
            if (w.last)
              end_block(w.data, (lit_left == 0 && out_count == out_size) ? StOk : StBadFinal);
            else begin
              if (lit_left == 0) ph = P_OFF_LO;
              add(w.data, 1'b0, StOk, 1'b0);
            end
          end
        end
        P_OFF_LO: begin
          if (w.last) end_block(8'h00, StBadFinal);
          else begin
            mat_off = w.data;
            ph = P_OFF_HI;
          end
        end
        P_OFF_HI: begin
          if (w.last) end_block(8'h00, StBadFinal);
          else begin
            mat_off = (mat_off & 8'hFF) | (int'(w.data) << 8);
            if (mat_nib == NibMax) begin
              mat_left = NibMax;
              ph = P_MAT_EXT;
            end else start_match(mat_nib + MinMatch);
          end
        end
        P_MAT_EXT: begin
          if (w.last) end_block(8'h00, StBadFinal);
          else begin
            mat_left = sat24(mat_left, w.data);
            if (w.data != 8'hFF) start_match(sat24(mat_left, MinMatch));
          end
        end
        default: ;
      endcase
    endfunction

    task check(res_t got);
      res_t exp;
      if (expect_q.size() == 0) begin
        report($sformatf("unexpected result byte %02h st %0d", got.out_byte, got.status));
        return;
      end
      exp = expect_q.pop_front();
      if (got.out_byte !== exp.out_byte)
        report($sformatf("out_byte %02h, want %02h", got.out_byte, exp.out_byte));
      if (got.copy_pending !== exp.copy_pending)
        report($sformatf("copy_pending %0b, want %0b", got.copy_pending, exp.copy_pending));
      if (got.status !== exp.status)
        report($sformatf("status %0d, want %0d", got.status, exp.status));
      if (got.block_done !== exp.block_done)
        report($sformatf("block_done %0b, want %0b", got.block_done, exp.block_done));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [23:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // in_byte
  logic        s_axis_tuser;   // action
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // out_byte, copy_pending, status, zero pad
  logic        m_axis_tlast;

  lz4_scoreboard sb;
  word_t         word_q[$];     // words still to be sent
  int unsigned   plan_count;    // output bytes the planned stream produces
  int            results_seen;
  int            idle_cycles;
  bit            send_burst;
  bit            recv_burst;

  lz4_block_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // sample both sides at the rising edge; inputs are predicted before results are checked
  always @(posedge clk_i) begin
    res_t got;
    word_t w;
    bit busy;
    if (rst_ni) begin
      busy = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        w.act = s_axis_tuser; w.data = s_axis_tdata; w.last = s_axis_tlast;
        sb.note(w);
        busy = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.out_byte = m_axis_tdata[7:0];
        got.copy_pending = m_axis_tdata[8];
        got.status = m_axis_tdata[10:9];
        got.block_done = m_axis_tlast;
        sb.check(got);
        results_seen <= results_seen + 1;
        busy = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        sb.out_size = cfg_data;
        busy = 1'b1;
      end
      idle_cycles <= busy ? 0 : idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL lz4_block_decoder");
        $finish;
      end
    end
  end

  // receiver: random stalls, occasional stall-free stretches, one long hold-off
  initial begin
    int stall;
    bit held;
    held = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (results_seen % 64 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      stall = recv_burst ? 0 : $urandom_range(0, 19);
      if (!held && results_seen >= 150) begin
        held = 1;
        stall = 400;   // lets the decoder fill up and push back on s_axis
      end
      if (stall > 0) begin
        m_axis_tready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  task automatic write_size(input int unsigned v);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_data = v[23:0];
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // drains the word queue with random gaps
  task automatic send_words();
    word_t w;
    int gap;
    while (word_q.size() > 0) begin
      w = word_q.pop_front();
      gap = send_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      s_axis_tvalid = 1'b1;
      s_axis_tdata = w.data;
      s_axis_tuser = w.act;
      s_axis_tlast = w.last;
      do @(posedge clk_i); while (!s_axis_tready);
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b0;
  endtask

  // waits until every expected word is back and the pipe is quiet
  task automatic wait_drained();
    while (sb.expect_q.size() > 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic put(input logic act, input logic [7:0] b, input logic last = 1'b0);
    word_t w;
    w.act = act; w.data = b; w.last = last;
    word_q.push_back(w);
  endtask

  // ignored words: pulls with no match pending or pushes during a match
  task automatic put_noise(input logic act);
    put(act, 8'($urandom), 1'($urandom));
  endtask

  task automatic put_offset(input int unsigned off);
    put(ActPush, off[7:0]);
    put(ActPush, off[15:8]);
  endtask

  task automatic put_pulls(input int unsigned len);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) put_noise(ActPush);
      put(ActPull, 8'($urandom));
    end
    plan_count += len;
  endtask

  // one well-formed sequence with random literal run and match
  task automatic put_sequence();
    int unsigned lit_len, nib, mlen, ext, off, r;
    r = $urandom_range(0, 99);
    if (r < 70) lit_len = $urandom_range(0, 6);
    else if (r < 90) lit_len = $urandom_range(7, 14);
    else lit_len = 15;
    if (plan_count == 0 && lit_len == 0) lit_len = 1;
    nib = ($urandom_range(0, 5) == 0) ? 15 : $urandom_range(0, 14);
    if ($urandom_range(0, 19) == 0) put_noise(ActPull);
    put(ActPush, {4'(lit_len), 4'(nib)});
    if (lit_len == 15) begin
      // long runs use the 255 continuation byte now and then
      if ($urandom_range(0, 9) == 0) begin
        put(ActPush, 8'hFF);
        lit_len += 255;
      end
      ext = $urandom_range(0, 10);
      put(ActPush, 8'(ext));
      lit_len += ext;
    end
    for (int i = 0; i < lit_len; i++) put(ActPush, 8'($urandom));
    plan_count += lit_len;
    off = ($urandom_range(0, 1) == 0) ? $urandom_range(1, (plan_count < 8) ? plan_count : 8)
                                      : $urandom_range(1, plan_count);
    put_offset(off);
    mlen = nib + MinMatch;
    if (nib == 15) begin
      if ($urandom_range(0, 9) == 0) begin
        put(ActPush, 8'hFF);
        mlen += 255;
      end
      ext = $urandom_range(0, 12);
      put(ActPush, 8'(ext));
      mlen += ext;
    end
    put_pulls(mlen);
  endtask

  // the block ends here, one way or another
  task automatic put_ending();
    int unsigned n;
    case ($urandom_range(0, 4))
      0: begin  // correct end on the last literal
        n = $urandom_range(1, 5);
        write_size(plan_count + n);
        put(ActPush, {4'(n), 4'($urandom)});
        for (int i = 0; i < n; i++) put(ActPush, 8'($urandom), i == n - 1);
      end
      1: begin  // correct end on a token with no literals
        write_size(plan_count);
        put(ActPush, {4'd0, 4'($urandom)}, 1'b1);
      end
      2: begin  // offset of zero or past the written output
        write_size(SizeMax);
        put(ActPush, 8'h10);
        put(ActPush, 8'($urandom));
        put_offset(($urandom_range(0, 1) == 0) ? 0 : plan_count + 2 + $urandom_range(0, 50));
      end
      3: begin  // literal with the output already full
        write_size(plan_count);
        put(ActPush, 8'h20);
        put(ActPush, 8'($urandom));
        put(ActPush, 8'($urandom));
      end
      default: begin  // match landing inside the last literals
        write_size(plan_count + MinMatch + 2);
        put(ActPush, 8'h00);
        put_offset(1);
      end
    endcase
    // all ignored once the block has ended
    for (int i = 0; i < 6; i++) put_noise(1'($urandom));
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tlast = 1'b0;
    results_seen = 0;
    idle_cycles = 0;
    plan_count = 0;
    send_burst = 0;
    recv_burst = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_size(0);
    write_size(SizeMax);

    // directed: extreme literals, overlapping match at offset one, ignored words
    put_noise(ActPull);
    put(ActPush, 8'h30);
    put(ActPush, 8'h00);
    put(ActPush, 8'hFF);
    put(ActPush, 8'hA5);
    put_offset(1);
    put(ActPull, 8'h00);
    put_noise(ActPush);
    put(ActPull, 8'hFF);
    put(ActPull, 8'h00);
    put(ActPull, 8'hFF);
    plan_count += 7;
    send_words();

    for (int ph = 0; ph < 3; ph++) begin
      wait_drained();
      write_size(ph == 1 ? $urandom_range(plan_count + 100000, SizeMax) : SizeMax);
      for (int s = 0; s < 7; s++) begin
        send_burst = ($urandom_range(0, 3) == 0);
        put_sequence();
        send_words();
      end
    end

    wait_drained();
    put_ending();
    send_words();
    wait_drained();

    if (sb.errors == 0) $display("PASS lz4_block_decoder");
    else $display("FAIL lz4_block_decoder");
    $finish;
  end

endmodule
